/* design/evad_pkg.sv */
`default_nettype none
package evad_pkg;

   // field widths of the request and response items and the configuration values
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned FORMAT_W  = 2;
   localparam int unsigned ENERGY_W  = 31;
   localparam int unsigned MIN_W     = 13;
   localparam int unsigned HOLD_W    = 24;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FRAME_SAMPLES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_SAMPLES      = 2'd2;

   localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 31'd10737418;
   localparam logic [MIN_W-1:0]    MIN_FRAME_RESET = 13'd160;
   localparam logic [HOLD_W-1:0]   HOLD_RESET      = 24'd8000;

   // sample format codes
   localparam logic [FORMAT_W-1:0] FMT_S16 = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_S8  = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_U8  = 2'd2;

   // magnitude of a Q1.15 sample and its square in unsigned Q1.30
   localparam int unsigned MAG_W = 16;
   localparam int unsigned SQ_W  = 31;

   // saturating sample counter since the last voice frame
   localparam int unsigned SINCE_W = 24;

   // frame summary queue between front and back end
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam int unsigned MAX_FRAME_DEFAULT = 4096;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

/* design/evad_req_if.sv */
`default_nettype none
interface evad_req_if;
   import evad_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_bits;
   logic [FORMAT_W-1:0] fmt_code;
   logic                frame_last;

   modport source (
      output valid, sample_bits, fmt_code, frame_last,
      input  ready
   );

   modport sink (
      input  valid, sample_bits, fmt_code, frame_last,
      output ready
   );

endinterface
`default_nettype wire

/* design/evad_rsp_if.sv */
`default_nettype none
interface evad_rsp_if;
   import evad_pkg::*;

   logic                valid;
   logic                ready;
   logic                speech_on;
   logic [ENERGY_W-1:0] mean_energy;

   modport source (
      output valid, speech_on, mean_energy,
      input  ready
   );

   modport sink (
      input  valid, speech_on, mean_energy,
      output ready
   );

endinterface
`default_nettype wire

/* design/evad_front.sv */
`default_nettype none
module evad_front #(
   parameter int unsigned MAX_FRAME = evad_pkg::MAX_FRAME_DEFAULT,
   parameter int unsigned CNT_W     = $clog2(MAX_FRAME + 1),
   parameter int unsigned SUM_W     = 30 + $clog2(MAX_FRAME + 1),
   parameter int unsigned LEVEL_W   = $clog2(evad_pkg::QUEUE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   evad_req_if.sink                    req_chan,
   input  logic [LEVEL_W-1:0]          queue_level,
   output logic                        push_valid,
   output logic [SUM_W-1:0]            push_sum,
   output logic [CNT_W-1:0]            push_count,
   output logic [evad_pkg::SINCE_W-1:0] push_adv
);
   import evad_pkg::*;

   logic              accept;
   logic              known;
   logic [MAG_W-1:0]  mag;
   logic [7:0]        byte_val;
   logic [7:0]        byte_abs;

   logic              s1_valid_ff;
   logic              s1_known_ff;
   logic              s1_last_ff;
   logic [MAG_W-1:0]  s1_mag_ff;

   logic              s2_valid_ff;
   logic              s2_known_ff;
   logic              s2_last_ff;
   logic [SQ_W-1:0]   s2_sq_ff;
   logic [SQ_W-1:0]   product;

   logic [SUM_W-1:0]   sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0]   count_ff, count_in, count_next;
   logic [SINCE_W-1:0] adv_ff, adv_in, adv_next;
   logic               take;

   // at most three frame ends can be in flight behind this check
   assign req_chan.ready = (queue_level <= LEVEL_W'(QUEUE_DEPTH - 3));
   assign accept         = req_chan.valid & req_chan.ready;

   // normalize the sample to a Q1.15 magnitude
   always_comb begin
      byte_val = (req_chan.fmt_code == FMT_U8) ?
                 {~req_chan.sample_bits[7], req_chan.sample_bits[6:0]} :
                 req_chan.sample_bits[7:0];
      byte_abs = byte_val[7] ? (~byte_val + 8'd1) : byte_val;
      case (req_chan.fmt_code)
         FMT_S16: begin
            known = 1'b1;
            mag   = req_chan.sample_bits[15] ?
                    (~req_chan.sample_bits + 16'd1) : req_chan.sample_bits;
         end
         FMT_S8, FMT_U8: begin
            known = 1'b1;
            mag   = {byte_abs, 8'd0};
         end
         default: begin
            known = 1'b0;
            mag   = '0;
         end
      endcase
   end

   // stage 1: registered magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_known_ff <= known;
      s1_last_ff  <= req_chan.frame_last;
      s1_mag_ff   <= mag;
   end

   // stage 2: registered square, at most 2^30
   assign product = SQ_W'(32'(s1_mag_ff) * 32'(s1_mag_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_known_ff <= s1_known_ff;
      s2_last_ff  <= s1_last_ff;
      s2_sq_ff    <= product;
   end

   // stage 3: frame accumulation and hand-off at frame end
   always_comb begin
      take       = s2_known_ff && (count_ff < CNT_W'(MAX_FRAME));
      sum_next   = take ? (sum_ff + SUM_W'(s2_sq_ff)) : sum_ff;
      count_next = take ? (count_ff + CNT_W'(1)) : count_ff;
      adv_next   = (s2_known_ff && (adv_ff != {SINCE_W{1'b1}})) ?
                   (adv_ff + SINCE_W'(1)) : adv_ff;

      push_valid = s2_valid_ff && s2_last_ff && (count_next != '0);
      push_sum   = sum_next;
      push_count = count_next;
      push_adv   = adv_next;

      sum_in   = sum_ff;
      count_in = count_ff;
      adv_in   = adv_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            sum_in   = '0;
            count_in = '0;
            adv_in   = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
            adv_in   = adv_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         adv_ff   <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         adv_ff   <= adv_in;
      end
   end

endmodule
`default_nettype wire

/* design/evad_queue.sv */
`default_nettype none
module evad_queue #(
   parameter int unsigned WIDTH   = 80,
   parameter int unsigned LEVEL_W = $clog2(evad_pkg::QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic               pop_valid,
   output logic [WIDTH-1:0]   pop_data,
   output logic [LEVEL_W-1:0] level
);
   import evad_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0]   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               do_pop;

   assign pop_valid = (level_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign do_pop    = pop && pop_valid;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (!push && do_pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* design/evad_back.sv */
`default_nettype none
module evad_back #(
   parameter int unsigned MAX_FRAME = evad_pkg::MAX_FRAME_DEFAULT,
   parameter int unsigned CNT_W     = $clog2(MAX_FRAME + 1),
   parameter int unsigned SUM_W     = 30 + $clog2(MAX_FRAME + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  logic [SUM_W-1:0]              pop_sum,
   input  logic [CNT_W-1:0]              pop_count,
   input  logic [evad_pkg::SINCE_W-1:0]  pop_adv,
   output logic                          pop,
   input  logic [evad_pkg::ENERGY_W-1:0] energy_limit,
   input  logic [evad_pkg::MIN_W-1:0]    min_frame_samples,
   input  logic [evad_pkg::HOLD_W-1:0]   hold_samples,
   evad_rsp_if.source                    rsp_chan
);
   import evad_pkg::*;

   localparam int unsigned STEP_W = $clog2(SUM_W + 1);
   localparam int unsigned CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [SINCE_W-1:0]  adv_ff, adv_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SINCE_W-1:0]  since_ff, since_in;
   logic                active_ff, active_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_voice_ff, out_voice_in;
   logic [ENERGY_W-1:0] out_energy_ff, out_energy_in;

   logic [CNT_W:0]      rem_shift;
   logic [SINCE_W:0]    since_sum;
   logic [SINCE_W-1:0]  since_sat;
   logic                voice;
   logic                rsp_take;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.speech_on   = out_voice_ff;
   assign rsp_chan.mean_energy = out_energy_ff;

   // sequencer: pop a frame, divide one quotient bit a cycle, then decide
   always_comb begin
      state_in      = state_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      adv_in        = adv_ff;
      step_in       = step_ff;
      since_in      = since_ff;
      active_in     = active_ff;
      out_voice_in  = out_voice_ff;
      out_energy_in = out_energy_ff;
      pop           = 1'b0;

      rsp_take     = out_valid_ff && rsp_chan.ready;
      out_valid_in = out_valid_ff && !rsp_take;

      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      since_sum = {1'b0, since_ff} + {1'b0, adv_ff};
      since_sat = since_sum[SINCE_W] ? {SINCE_W{1'b1}} : since_sum[SINCE_W-1:0];
      voice     = (quo_ff[ENERGY_W-1:0] > energy_limit) &&
                  (CMP_W'(div_ff) >= CMP_W'(min_frame_samples));

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               quo_in   = pop_sum;
               rem_in   = '0;
               div_in   = pop_count;
               adv_in   = pop_adv;
               step_in  = STEP_W'(SUM_W);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // restoring division step
            if (rem_shift >= {1'b0, div_ff}) begin
               rem_in = CNT_W'(rem_shift - {1'b0, div_ff});
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // activity decision with hangover, result into the output register
            if (!out_valid_ff || rsp_take) begin
               if (voice) begin
                  active_in = 1'b1;
                  since_in  = '0;
               end else begin
                  since_in = since_sat;
                  if (active_ff && (since_sat > hold_samples)) begin
                     active_in = 1'b0;
                  end
               end
               out_valid_in  = 1'b1;
               out_voice_in  = voice ? 1'b1 :
                               (active_ff && !(since_sat > hold_samples));
               out_energy_in = quo_ff[ENERGY_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff     <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         since_ff     <= since_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // divider and result payload
   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      adv_ff        <= adv_in;
      step_ff       <= step_in;
      out_voice_ff  <= out_voice_in;
      out_energy_ff <= out_energy_in;
   end

endmodule
`default_nettype wire

/* design/energy_voice_activity_detector.sv */
// Energy voice activity detector. Audio samples (signed 16-bit, signed 8-bit or
// unsigned 8-bit, format code 3 ignored) enter on req_chan, one per cycle while
// req_chan.ready is high, and are squared and summed per frame in a three-stage
// front end. On the sample marked frame_last a frame summary goes into a
// four-entry queue; the back end divides the sum by the sample count with a
// one-bit-per-cycle divider (30 + clog2(MAX_FRAME+1) steps, 43 for MAX_FRAME
// 4096), applies threshold, minimum frame length and hangover, and raises
// rsp_chan.valid with the result. The back end handles one frame at a time
// (one pop, 43 divide steps, one decision), so short frames can fill the queue
// and req_chan.ready drops until it catches up. Empty frames give no result.
// The user must write registers on the csr_ port only while idle; the block
// itself does not enforce this.
`default_nettype none
module energy_voice_activity_detector #(
   parameter int unsigned MAX_FRAME = evad_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   evad_req_if.sink                         req_chan,
   evad_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [evad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import evad_pkg::*;

   localparam int unsigned CNT_W   = $clog2(MAX_FRAME + 1);
   localparam int unsigned SUM_W   = 30 + $clog2(MAX_FRAME + 1);
   localparam int unsigned ENTRY_W = SUM_W + CNT_W + SINCE_W;
   localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   logic [ENERGY_W-1:0] threshold_ff;
   logic [MIN_W-1:0]    min_frame_ff;
   logic [HOLD_W-1:0]   hold_ff;

   logic               push_valid;
   logic [SUM_W-1:0]   push_sum;
   logic [CNT_W-1:0]   push_count;
   logic [SINCE_W-1:0] push_adv;
   logic [LEVEL_W-1:0] queue_level;
   logic               pop;
   logic               pop_valid;
   logic [ENTRY_W-1:0] pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_frame_ff <= MIN_FRAME_RESET;
         hold_ff      <= HOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENERGY_LIMIT:      threshold_ff <= csr_wdata[ENERGY_W-1:0];
            CSR_MIN_FRAME_SAMPLES: min_frame_ff <= csr_wdata[MIN_W-1:0];
            CSR_HOLD_SAMPLES:      hold_ff      <= csr_wdata[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample intake and frame accumulation
   evad_front #(
      .MAX_FRAME (MAX_FRAME),
      .CNT_W     (CNT_W),
      .SUM_W     (SUM_W),
      .LEVEL_W   (LEVEL_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .queue_level (queue_level),
      .push_valid  (push_valid),
      .push_sum    (push_sum),
      .push_count  (push_count),
      .push_adv    (push_adv)
   );

   // frame summaries waiting for the divider
   evad_queue #(
      .WIDTH   (ENTRY_W),
      .LEVEL_W (LEVEL_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_sum, push_count, push_adv}),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .level     (queue_level)
   );

   // mean-square division and activity decision
   evad_back #(
      .MAX_FRAME (MAX_FRAME),
      .CNT_W     (CNT_W),
      .SUM_W     (SUM_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_sum           (pop_data[ENTRY_W-1 -: SUM_W]),
      .pop_count         (pop_data[SINCE_W +: CNT_W]),
      .pop_adv           (pop_data[SINCE_W-1:0]),
      .pop               (pop),
      .energy_limit      (threshold_ff),
      .min_frame_samples (min_frame_ff),
      .hold_samples      (hold_ff),
      .rsp_chan          (rsp_chan)
   );

endmodule
`default_nettype wire
